// ----- hdl/spp_pkg.sv -----
// Shared types and constants for the strings file pair parser.
`default_nettype none
package spp_pkg;

  typedef struct packed {
    logic [7:0] byte_req;
    logic       end_of_data;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  value;
    logic [2:0]  code;
    logic [15:0] line;
    logic        last;
  } out_t;

  // Up to two results produced by one input beat.
  typedef struct packed {
    logic first_ok;
    logic second_ok;
    out_t first;
    out_t second;
  } res_pair_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_SLASH   = 4'd1,
    PH_COMMENT = 4'd2,
    PH_STAR    = 4'd3,
    PH_KEY     = 4'd4,
    PH_SEP     = 4'd5,
    PH_EQ      = 4'd6,
    PH_TEXT    = 4'd7,
    PH_TERM    = 4'd8,
    PH_HALT    = 4'd9
  } phase_t;

  // Result kinds
  localparam logic [2:0] K_KEY    = 3'd0;
  localparam logic [2:0] K_TEXT   = 3'd1;
  localparam logic [2:0] K_PAIR   = 3'd2;
  localparam logic [2:0] K_END_OK = 3'd3;
  localparam logic [2:0] K_WARN   = 3'd4;
  localparam logic [2:0] K_ERROR  = 3'd5;

  // Error and warning codes
  localparam logic [2:0] E_SYNTAX     = 3'd0;
  localparam logic [2:0] E_UNTERM_KEY = 3'd1;
  localparam logic [2:0] E_NO_SEP     = 3'd2;
  localparam logic [2:0] E_NO_TEXT    = 3'd3;
  localparam logic [2:0] E_UNTERM_TXT = 3'd4;
  localparam logic [2:0] E_NO_TERM    = 3'd5;
  localparam logic [2:0] W_ESC_KEY    = 3'd6;
  localparam logic [2:0] W_ESC_TEXT   = 3'd7;

  // Escape progress
  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_BS    = 2'd1;
  localparam logic [1:0] ESC_OCT1  = 2'd2;
  localparam logic [1:0] ESC_OCT2  = 2'd3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_THREE  = 8'h33;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam int QDEPTH = 4;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage
`default_nettype wire

// ----- hdl/strings_file_pair_parser_top.sv -----
// Top level of the strings file pair parser.
// A beat's results are in the queue the cycle after the beat is accepted.
// Throughput: one input byte per cycle while results drain at the same rate;
// a byte giving two results takes two entries of the 4-entry queue.
// Reset (rst, synchronous): parser back between pairs, line 1, queue empty.
`default_nettype none
module strings_file_pair_parser_top #(
  parameter int STRING_BUFFER = 1024,
  parameter int LINE_BITS     = 16
) (
  input  wire           logic clk,
  input  wire           logic rst,
  input  wire           logic src_valid,
  output logic          src_ready,
  input  spp_pkg::in_t  src_data,
  output logic          res_valid,
  input  wire           logic res_ready,
  output spp_pkg::out_t res_data
);
  import spp_pkg::*;

  res_pair_t pair;
  logic      go;

  assign go = src_valid && src_ready;

  spp_core #(
    .STRING_BUFFER(STRING_BUFFER),
    .LINE_BITS    (LINE_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .src_data(src_data),
    .pair    (pair)
  );

  spp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .pair     (pair),
    .src_ready(src_ready),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

endmodule
`default_nettype wire

// ----- hdl/spp_core.sv -----
// Parser state and the combinational step logic for one input byte.
`default_nettype none
module spp_core #(
  parameter int STRING_BUFFER = 1024,
  parameter int LINE_BITS     = 16
) (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic go,
  input  spp_pkg::in_t       src_data,
  output spp_pkg::res_pair_t pair
);
  import spp_pkg::*;

  localparam int LEN_W = $clog2(STRING_BUFFER);

  typedef struct packed {
    phase_t ph;
    logic   emit;
    logic [2:0] kind;
    logic [2:0] code;
    logic   cnt;
    logic   start;
  } gap_t;

  phase_t             phase, phase_next;
  logic [1:0]         escape_step, escape_step_next;
  logic [4:0]         octal_partial, octal_partial_next;
  logic [LEN_W-1:0]   string_length, string_length_next;
  logic [LINE_BITS-1:0] line_count, line_count_next;

  logic       end_in;
  logic [7:0] c;
  phase_t     gap_in;
  gap_t       gap;

  logic       e0, e1, cnt, start, store, is_text;
  logic [2:0] k0, c0, k1, c1;
  logic [7:0] v0, store_val;
  phase_t     str_next;
  logic [2:0] warn_code, after_code;
  logic       oct_dig, low_dig;
  logic [7:0] oct_byte;

  assign end_in = src_data.end_of_data || (src_data.byte_req == CH_NUL);
  assign c      = end_in ? CH_NUL : src_data.byte_req;

  assign is_text    = (phase == PH_TEXT);
  assign str_next   = is_text ? PH_TERM : PH_SEP;
  assign warn_code  = is_text ? W_ESC_TEXT : W_ESC_KEY;
  assign after_code = is_text ? E_NO_TERM : E_NO_SEP;
  assign oct_dig    = (c >= CH_ZERO) && (c <= CH_SEVEN);
  assign low_dig    = (c >= CH_ZERO) && (c <= CH_THREE);
  assign oct_byte   = {octal_partial, 3'b000} | {5'd0, c[2:0]};

  // Which between-token phase the gap logic evaluates
  always_comb begin
    if (phase == PH_KEY) gap_in = PH_SEP;
    else if (phase == PH_TEXT) gap_in = PH_TERM;
    else gap_in = phase;
  end

  always_comb begin
    gap = '{ph: gap_in, emit: 1'b0, kind: K_ERROR, code: E_SYNTAX, cnt: 1'b0, start: 1'b0};
    unique case (gap_in)
      PH_SEP: begin
        if (is_ws(c)) gap.cnt = 1'b1;
        else if (c == CH_EQUAL) gap.ph = PH_EQ;
        else begin
          gap.emit = 1'b1;
          gap.code = E_NO_SEP;
          gap.ph   = PH_HALT;
        end
      end
      PH_EQ: begin
        if (is_ws(c)) gap.cnt = 1'b1;
        else if (c == CH_QUOTE) begin
          gap.ph    = PH_TEXT;
          gap.start = 1'b1;
        end else begin
          gap.emit = 1'b1;
          gap.code = E_NO_TEXT;
          gap.ph   = PH_HALT;
        end
      end
      default: begin
        if (c == CH_SEMI) begin
          gap.emit = 1'b1;
          gap.kind = K_PAIR;
          gap.ph   = PH_IDLE;
        end else begin
          gap.emit = 1'b1;
          gap.code = E_NO_TERM;
          gap.ph   = PH_HALT;
        end
      end
    endcase
  end

  always_comb begin
    phase_next         = phase;
    escape_step_next   = escape_step;
    octal_partial_next = octal_partial;
    e0 = 1'b0; e1 = 1'b0; cnt = 1'b0; start = 1'b0; store = 1'b0;
    k0 = K_ERROR; c0 = E_SYNTAX; v0 = 8'd0;
    k1 = K_ERROR; c1 = E_SYNTAX;
    store_val = c;
    unique case (phase)
      PH_IDLE: begin
        if (end_in) begin
          e0 = 1'b1; k0 = K_END_OK;
        end else if (is_ws(c)) cnt = 1'b1;
        else if (c == CH_SLASH) phase_next = PH_SLASH;
        else if (c == CH_QUOTE) begin
          phase_next = PH_KEY;
          start      = 1'b1;
        end else begin
          e0 = 1'b1; phase_next = PH_HALT;
        end
      end
      PH_SLASH: begin
        if (c == CH_STAR) phase_next = PH_COMMENT;
        else begin
          e0 = 1'b1; phase_next = PH_HALT;
        end
      end
      PH_COMMENT, PH_STAR: begin
        if (end_in) begin
          e0 = 1'b1; k0 = K_END_OK;
        end else if (phase == PH_STAR && c == CH_SLASH) phase_next = PH_IDLE;
        else if (c == CH_STAR) phase_next = PH_STAR;
        else begin
          cnt        = 1'b1;
          phase_next = PH_COMMENT;
        end
      end
      PH_KEY, PH_TEXT: begin
        if (end_in) begin
          e0 = 1'b1;
          phase_next = PH_HALT;
          escape_step_next = ESC_NONE;
          if (escape_step[1]) begin
            k0 = K_WARN; c0 = warn_code;
            e1 = 1'b1;   c1 = after_code;
          end else begin
            c0 = is_text ? E_UNTERM_TXT : E_UNTERM_KEY;
          end
        end else begin
          unique case (escape_step)
            ESC_NONE: begin
              if (c == CH_QUOTE) phase_next = str_next;
              else if (c == CH_BSLASH) escape_step_next = ESC_BS;
              else store = 1'b1;
            end
            ESC_BS: begin
              escape_step_next = ESC_NONE;
              if (c == CH_BSLASH || c == CH_APOS || c == CH_QUOTE) store = 1'b1;
              else if (c == CH_N) begin
                store = 1'b1; store_val = CH_LF;
              end else if (c == CH_R) begin
                store = 1'b1; store_val = CH_CR;
              end else if (c == CH_T) begin
                store = 1'b1; store_val = CH_TAB;
              end else if (low_dig) begin
                octal_partial_next = {3'd0, c[1:0]};
                escape_step_next   = ESC_OCT1;
              end else begin
                e0 = 1'b1; k0 = K_WARN; c0 = warn_code;
                phase_next = str_next;
              end
            end
            ESC_OCT1: begin
              if (oct_dig) begin
                octal_partial_next = {octal_partial[1:0], c[2:0]};
                escape_step_next   = ESC_OCT2;
              end else begin
                // string ends; the byte is parsed again as the next token
                e0 = 1'b1; k0 = K_WARN; c0 = warn_code;
                escape_step_next = ESC_NONE;
                phase_next = gap.ph;
                e1 = gap.emit; k1 = gap.kind; c1 = gap.code;
                cnt = gap.cnt; start = gap.start;
              end
            end
            default: begin
              escape_step_next = ESC_NONE;
              if (oct_dig) begin
                store = 1'b1; store_val = oct_byte;
              end else begin
                e0 = 1'b1; k0 = K_WARN; c0 = warn_code;
                e1 = 1'b1; c1 = after_code;
                phase_next = PH_HALT;
              end
            end
          endcase
        end
      end
      PH_SEP, PH_EQ, PH_TERM: begin
        phase_next = gap.ph;
        e0 = gap.emit; k0 = gap.kind; c0 = gap.code;
        cnt = gap.cnt; start = gap.start;
      end
      default: begin
      end
    endcase

    string_length_next = string_length;
    if (store && string_length < LEN_W'(STRING_BUFFER - 1)) begin
      e0 = 1'b1;
      k0 = is_text ? K_TEXT : K_KEY;
      v0 = store_val;
      string_length_next = string_length + LEN_W'(1);
    end
    if (start) begin
      string_length_next = '0;
      escape_step_next   = ESC_NONE;
    end

    line_count_next = line_count;
    if (cnt && c == CH_LF && line_count != {LINE_BITS{1'b1}})
      line_count_next = line_count + LINE_BITS'(1);

    // end of data always returns to the reset state
    if (end_in) begin
      phase_next         = PH_IDLE;
      escape_step_next   = ESC_NONE;
      octal_partial_next = '0;
      string_length_next = '0;
      line_count_next    = LINE_BITS'(1);
    end
  end

  always_comb begin
    pair.first_ok     = go && e0;
    pair.second_ok    = go && e1;
    pair.first.kind   = k0;
    pair.first.value  = v0;
    pair.first.code   = c0;
    pair.first.line   = 16'(line_count);
    pair.first.last   = !e1;
    pair.second.kind  = k1;
    pair.second.value = 8'd0;
    pair.second.code  = c1;
    pair.second.line  = 16'(line_count);
    pair.second.last  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      escape_step   <= ESC_NONE;
      octal_partial <= '0;
      string_length <= '0;
      line_count    <= LINE_BITS'(1);
    end else if (go) begin
      phase         <= phase_next;
      escape_step   <= escape_step_next;
      octal_partial <= octal_partial_next;
      string_length <= string_length_next;
      line_count    <= line_count_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/spp_queue.sv -----
// Result queue: takes up to two results per cycle, delivers one beat per cycle while res_ready is high.
`default_nettype none
module spp_queue (
  input  wire                logic clk,
  input  wire                logic rst,
  input  spp_pkg::res_pair_t pair,
  output logic               src_ready,
  output logic               res_valid,
  input  wire                logic res_ready,
  output spp_pkg::out_t      res_data
);
  import spp_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  out_t             slots [QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] n_push;
  logic             pop;

  assign n_push    = PTR_W'(pair.first_ok) + PTR_W'(pair.second_ok);
  assign pop       = res_valid && res_ready;
  assign res_valid = (count != '0);
  assign res_data  = slots[rd_ptr];
  // room for a full pair regardless of the output side
  assign src_ready = (count <= CNT_W'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (pair.first_ok) slots[wr_ptr] <= pair.first;
    if (pair.second_ok) slots[wr_ptr + PTR_W'(1)] <= pair.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(n_push) - CNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/spp_checker.sv -----
// Port-level checks for the parser top level, with the bind that attaches them.
`default_nettype none
module spp_checker (
  input wire           logic clk,
  input wire           logic rst,
  input wire           logic src_valid,
  input wire           logic src_ready,
  input spp_pkg::in_t  src_data,
  input wire           logic res_valid,
  input wire           logic res_ready,
  input spp_pkg::out_t res_data
);
  import spp_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result beat changed while stalled");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.kind != K_KEY && res_data.kind != K_TEXT |-> res_data.value == 8'd0)
    else $error("value set on a non-byte result");

  a_warn_code: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.kind == K_WARN |->
      res_data.code == W_ESC_KEY || res_data.code == W_ESC_TEXT)
    else $error("warning without an escape code");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.line != 16'd0)
    else $error("line number zero");

endmodule

bind strings_file_pair_parser_top spp_checker u_spp_checker (
  .clk      (clk),
  .rst      (rst),
  .src_valid(src_valid),
  .src_ready(src_ready),
  .src_data (src_data),
  .res_valid(res_valid),
  .res_ready(res_ready),
  .res_data (res_data)
);
`default_nettype wire
